/* sv/baro_pressure_temp_compensation_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Implication checks in same-cycle and next-cycle form, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define BPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("baro compensation: same-cycle check failed");
`define BPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("baro compensation: next-cycle check failed");
`else
`define BPC_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define BPC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

/* sv/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Widths, register indexes and shared types of the compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int DT_W    = 25;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 25;
  localparam int WIDE_W  = 40;
  localparam int IDX_W   = 3;
  localparam int LATENCY = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;

  localparam logic [IDX_W-1:0] CFG_SENS      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_OFFSET    = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SENS_TC   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_OFFSET_TC = 3'd3;
  localparam logic [IDX_W-1:0] CFG_TREF      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_TEMP_SENS = 3'd5;
  localparam logic [IDX_W-1:0] CFG_DOUBLE    = 3'd6;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] offset;
    logic [COEF_W-1:0] sens_tc;
    logic [COEF_W-1:0] offset_tc;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] temp_sens;
    logic              double_pressure;
  } coeff_t;

  typedef struct packed {
    logic                     valid;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp1;
    logic signed [TEMP_W-1:0] temp2;
    logic signed [WIDE_W-1:0] off_net;
    logic signed [WIDE_W-1:0] sens_net;
  } comp_t;

endpackage

/* sv/baro_pressure_temp_compensation.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order pressure and temperature compensation of raw sensor readings.
// ----------------------------------------------------------------------------
// One reading pair is taken per clock when start is high and busy is low;
// busy is high only during reset. Each pair yields one result, marked by a
// one-cycle done pulse; results cannot be held off, so the pipeline never
// stalls. The datapath has eight stages, and every multiplier is followed
// by a register. Calibration writes are taken at any time on the cfg
// channel but belong to idle periods.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation
  import bpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [RAW_W-1:0]          raw_pressure,
  input  logic [RAW_W-1:0]          raw_temperature,
  output logic                      done,
  output logic signed [TEMP_W-1:0]  temp_first_centi,
  output logic signed [TEMP_W-1:0]  temp_centi,
  output logic signed [PRESS_W-1:0] pressure_pa,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [COEF_W-1:0]         cfg_data
);

  coeff_t coeff;
  comp_t  comp;
  logic   in_fire;

  assign busy    = rst;
  assign in_fire = start && !busy;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coeff     (coeff)
  );

  bpc_comp_pipe u_comp (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_fire),
    .raw_pressure    (raw_pressure),
    .raw_temperature (raw_temperature),
    .coeff           (coeff),
    .comp            (comp)
  );

  bpc_press_pipe u_press (
    .clk              (clk),
    .rst              (rst),
    .comp             (comp),
    .double_pressure  (coeff.double_pressure),
    .done             (done),
    .temp_first_centi (temp_first_centi),
    .temp_centi       (temp_centi),
    .pressure_pa      (pressure_pa)
  );

  `BPC_ASSERT_IMP(a_latency, clk, rst, 1'b1, done == $past(in_fire, LATENCY))
  `BPC_ASSERT_IMP(a_temp_order, clk, rst, done, temp_centi <= temp_first_centi)
  `BPC_ASSERT_IMP(a_warm_no_corr, clk, rst, done && temp_first_centi >= TEMP_REF, temp_centi == temp_first_centi)

endmodule

/* sv/bpc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Calibration register file written through the configuration channel.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_assert.svh"

module bpc_cfg_regs
  import bpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [COEF_W-1:0]   cfg_data,
  output coeff_t              coeff
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= '{default: '0, double_pressure: 1'b1};
    end else if (wr) begin
      unique case (cfg_index)
        CFG_SENS:      coeff.sens            <= cfg_data;
        CFG_OFFSET:    coeff.offset          <= cfg_data;
        CFG_SENS_TC:   coeff.sens_tc         <= cfg_data;
        CFG_OFFSET_TC: coeff.offset_tc       <= cfg_data;
        CFG_TREF:      coeff.tref            <= cfg_data;
        CFG_TEMP_SENS: coeff.temp_sens       <= cfg_data;
        CFG_DOUBLE:    coeff.double_pressure <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  `BPC_ASSERT_NXT(a_double_write, clk, rst, wr && cfg_index == CFG_DOUBLE, coeff.double_pressure == $past(cfg_data[0]))
  `BPC_ASSERT_NXT(a_ignore_high, clk, rst, wr && cfg_index != CFG_SENS && cfg_index != CFG_OFFSET && cfg_index != CFG_SENS_TC && cfg_index != CFG_OFFSET_TC && cfg_index != CFG_TREF && cfg_index != CFG_TEMP_SENS && cfg_index != CFG_DOUBLE, $stable(coeff))

endmodule

/* sv/bpc_comp_pipe.sv */
// ----------------------------------------------------------------------------
// bpc_comp_pipe
// Temperature, offset and sensitivity stages with second-order correction.
// ----------------------------------------------------------------------------
module bpc_comp_pipe
  import bpc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  input  coeff_t           coeff,
  output comp_t            comp
);

  // stage 1: temperature difference
  logic                   v1;
  logic [RAW_W-1:0]       d1_s1;
  logic signed [DT_W-1:0] dt_s1;

  // stage 2: products
  logic                   v2;
  logic [RAW_W-1:0]       d1_s2;
  logic signed [41:0]     tsens_prod;
  logic signed [41:0]     offtc_prod;
  logic signed [41:0]     senstc_prod;
  logic signed [49:0]     dtsq_prod;

  // stage 3: first-order terms
  logic                     v3;
  logic [RAW_W-1:0]         d1_s3;
  logic signed [TEMP_W-1:0] temp1_s3;
  logic signed [17:0]       dtemp_s3;
  logic                     low_s3;
  logic [17:0]              t2_s3;
  logic signed [WIDE_W-1:0] off_s3;
  logic signed [WIDE_W-1:0] sens_s3;

  // stage 4: square of the temperature deficit
  logic                     v4;
  logic [RAW_W-1:0]         d1_s4;
  logic signed [TEMP_W-1:0] temp1_s4;
  logic signed [TEMP_W-1:0] temp2_s4;
  logic                     low_s4;
  logic [34:0]              dsq_s4;
  logic signed [WIDE_W-1:0] off_s4;
  logic signed [WIDE_W-1:0] sens_s4;

  logic signed [35:0] dsq_full;
  logic [37:0]        five_dsq;
  logic [WIDE_W-1:0]  off2;
  logic [WIDE_W-1:0]  sens2;

  assign dsq_full = dtemp_s3 * dtemp_s3;
  assign five_dsq = 38'(dsq_s4) + {1'b0, dsq_s4, 2'b00};
  assign off2     = low_s4 ? WIDE_W'(five_dsq[37:1]) : '0;
  assign sens2    = low_s4 ? WIDE_W'(five_dsq[37:2]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      comp.valid <= 1'b0;
    end else begin
      v1         <= in_valid;
      v2         <= v1;
      v3         <= v2;
      v4         <= v3;
      comp.valid <= v4;
    end

    d1_s1 <= raw_pressure;
    dt_s1 <= $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.tref, 8'b0});

    d1_s2       <= d1_s1;
    tsens_prod  <= dt_s1 * $signed({1'b0, coeff.temp_sens});
    offtc_prod  <= dt_s1 * $signed({1'b0, coeff.offset_tc});
    senstc_prod <= dt_s1 * $signed({1'b0, coeff.sens_tc});
    dtsq_prod   <= dt_s1 * dt_s1;

    d1_s3    <= d1_s2;
    temp1_s3 <= TEMP_REF + $signed(tsens_prod[41:23]);
    dtemp_s3 <= $signed(tsens_prod[40:23]);
    low_s3   <= tsens_prod[41];
    t2_s3    <= dtsq_prod[48:31];
    off_s3   <= $signed({8'b0, coeff.offset, 16'b0}) + WIDE_W'($signed(offtc_prod[41:7]));
    sens_s3  <= $signed({9'b0, coeff.sens, 15'b0}) + WIDE_W'($signed(senstc_prod[41:8]));

    d1_s4    <= d1_s3;
    temp1_s4 <= temp1_s3;
    temp2_s4 <= low_s3 ? temp1_s3 - $signed({1'b0, t2_s3}) : temp1_s3;
    low_s4   <= low_s3;
    dsq_s4   <= dsq_full[34:0];
    off_s4   <= off_s3;
    sens_s4  <= sens_s3;

    comp.d1       <= d1_s4;
    comp.temp1    <= temp1_s4;
    comp.temp2    <= temp2_s4;
    comp.off_net  <= off_s4 - $signed(off2);
    comp.sens_net <= sens_s4 - $signed(sens2);
  end

endmodule

/* sv/bpc_press_pipe.sv */
// ----------------------------------------------------------------------------
// bpc_press_pipe
// Pressure stages: split multiply, offset subtract, doubling and saturation.
// ----------------------------------------------------------------------------
`include "baro_pressure_temp_compensation_assert.svh"

module bpc_press_pipe
  import bpc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  comp_t                     comp,
  input  logic                      double_pressure,
  output logic                      done,
  output logic signed [TEMP_W-1:0]  temp_first_centi,
  output logic signed [TEMP_W-1:0]  temp_centi,
  output logic signed [PRESS_W-1:0] pressure_pa
);

  localparam logic signed [31:0] P_MAX = 32'sd16777215;
  localparam logic signed [31:0] P_MIN = -32'sd16777216;

  // stage 6: partial products
  logic                     v6;
  logic signed [45:0]       pp_lo;
  logic signed [44:0]       pp_hi;
  logic signed [WIDE_W-1:0] off_s6;
  logic signed [TEMP_W-1:0] temp1_s6;
  logic signed [TEMP_W-1:0] temp2_s6;

  // stage 7: recombine and subtract offset
  logic                     v7;
  logic signed [45:0]       q_s7;
  logic signed [TEMP_W-1:0] temp1_s7;
  logic signed [TEMP_W-1:0] temp2_s7;

  logic signed [RAW_W:0]  d1_s;
  logic signed [64:0]     prod;
  logic signed [30:0]     p;
  logic signed [31:0]     p2;
  logic [PRESS_W-1:0]     p_sat;

  assign d1_s = $signed({1'b0, comp.d1});
  assign prod = $signed({pp_hi, 20'b0}) + 65'(pp_lo);
  assign p    = $signed(q_s7[45:15]);
  assign p2   = double_pressure ? $signed({p, 1'b0}) : 32'(p);

  always_comb begin
    priority if (p2 > P_MAX) begin
      p_sat = P_MAX[PRESS_W-1:0];
    end else if (p2 < P_MIN) begin
      p_sat = P_MIN[PRESS_W-1:0];
    end else begin
      p_sat = p2[PRESS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6   <= 1'b0;
      v7   <= 1'b0;
      done <= 1'b0;
    end else begin
      v6   <= comp.valid;
      v7   <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    pp_lo    <= d1_s * $signed({1'b0, comp.sens_net[19:0]});
    pp_hi    <= d1_s * $signed(comp.sens_net[39:20]);
    off_s6   <= comp.off_net;
    temp1_s6 <= comp.temp1;
    temp2_s6 <= comp.temp2;

    q_s7     <= 46'($signed(prod[64:21])) - 46'(off_s6);
    temp1_s7 <= temp1_s6;
    temp2_s7 <= temp2_s6;

    temp_first_centi <= temp1_s7;
    temp_centi       <= temp2_s7;
    pressure_pa      <= $signed(p_sat);
  end

  `BPC_ASSERT_IMP(a_valid_travel, clk, rst, 1'b1, done == $past(comp.valid, 3))

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: pressure and temperature compensation testbench
// Drives raw pressure/temperature reading pairs and calibration writes, and
// predicts the first-order temperature, the corrected temperature and the
// saturated pressure of every beat in 64-bit integer arithmetic. Each result
// strobe is checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb;
  import bpc_pkg::*;

  localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam longint TEMP_BASE = 2000;
  localparam longint PRESS_MAX = 16777215;
  localparam longint PRESS_MIN = -16777216;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 300;

  typedef struct packed {
    logic signed [TEMP_W-1:0]  temp_first;
    logic signed [TEMP_W-1:0]  temp;
    logic signed [PRESS_W-1:0] pressure;
  } reading_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [RAW_W-1:0]          raw_pressure = '0;
  logic [RAW_W-1:0]          raw_temperature = '0;
  logic                      done;
  logic signed [TEMP_W-1:0]  temp_first_centi;
  logic signed [TEMP_W-1:0]  temp_centi;
  logic signed [PRESS_W-1:0] pressure_pa;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [IDX_W-1:0]          cfg_index = '0;
  logic [COEF_W-1:0]         cfg_data = '0;

  coeff_t   calibration;
  reading_t expected_readings[$];
  int       mismatch_count = 0;
  int       stall_cycles = 0;

  baro_pressure_temp_compensation uut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .raw_pressure     (raw_pressure),
    .raw_temperature  (raw_temperature),
    .done             (done),
    .temp_first_centi (temp_first_centi),
    .temp_centi       (temp_centi),
    .pressure_pa      (pressure_pa),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic reading_t compensate(input logic [RAW_W-1:0] d1_raw,
                                          input logic [RAW_W-1:0] d2_raw,
                                          input coeff_t c);
    longint   dt, t1, off, sns, t2, off2, sns2, dev, p;
    reading_t r;
    dt   = longint'(d2_raw) - longint'(c.tref) * 256;
    t1   = TEMP_BASE + ((dt * longint'(c.temp_sens)) >>> 23);
    off  = longint'(c.offset) * 65536 + ((longint'(c.offset_tc) * dt) >>> 7);
    sns  = longint'(c.sens) * 32768 + ((longint'(c.sens_tc) * dt) >>> 8);
    t2   = 0;
    off2 = 0;
    sns2 = 0;
    if (t1 < TEMP_BASE) begin
      dev  = t1 - TEMP_BASE;
      t2   = (dt * dt) >>> 31;
      off2 = (5 * dev * dev) / 2;
      sns2 = off2 / 2;
    end
    p = (((longint'(d1_raw) * (sns - sns2)) >>> 21) - (off - off2)) >>> 15;
    if (c.double_pressure)
      p = p * 2;
    if (p > PRESS_MAX)
      p = PRESS_MAX;
    if (p < PRESS_MIN)
      p = PRESS_MIN;
    r.temp_first = t1[TEMP_W-1:0];
    r.temp       = TEMP_W'(t1 - t2);
    r.pressure   = p[PRESS_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reading_t exp_r;
    if (rst) begin
      calibration = '0;
      calibration.double_pressure = 1'b1;
      expected_readings.delete();
    end else begin
      if (done) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing outstanding: %0d %0d %0d",
                     $time, temp_first_centi, temp_centi, pressure_pa);
        end else begin
          exp_r = expected_readings.pop_front();
          if (temp_first_centi !== exp_r.temp_first || temp_centi !== exp_r.temp ||
              pressure_pa !== exp_r.pressure) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"%0t: mismatch temp_first exp %0d got %0d, temp exp %0d got %0d,",
                        " pressure exp %0d got %0d"},
                       $time, exp_r.temp_first, temp_first_centi, exp_r.temp, temp_centi,
                       exp_r.pressure, pressure_pa);
          end
        end
      end
      if (start && !busy)
        expected_readings.push_back(compensate(raw_pressure, raw_temperature, calibration));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SENS:      calibration.sens = cfg_data;
          CFG_OFFSET:    calibration.offset = cfg_data;
          CFG_SENS_TC:   calibration.sens_tc = cfg_data;
          CFG_OFFSET_TC: calibration.offset_tc = cfg_data;
          CFG_TREF:      calibration.tref = cfg_data;
          CFG_TEMP_SENS: calibration.temp_sens = cfg_data;
          CFG_DOUBLE:    calibration.double_pressure = cfg_data[0];
          default: ;
        endcase
      end
    end
    if ((start && !busy) || done || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2,
                              input bit gaps);
    if (gaps && $urandom_range(0, 99) < 10) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    raw_pressure    <= d1;
    raw_temperature <= d2;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_calibration(input coeff_t c);
    wait_for_results();
    write_reg(CFG_SENS, c.sens);
    write_reg(CFG_OFFSET, c.offset);
    write_reg(CFG_SENS_TC, c.sens_tc);
    write_reg(CFG_OFFSET_TC, c.offset_tc);
    write_reg(CFG_TREF, c.tref);
    write_reg(CFG_TEMP_SENS, c.temp_sens);
    write_reg(CFG_DOUBLE, {15'h7FFF, c.double_pressure});
  endtask

  function automatic logic [COEF_W-1:0] random_coeff();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic test_reset_values();
    send_reading(24'h000000, 24'h000000, 1'b0);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_reading(24'hFFFFFF, 24'h000000, 1'b0);
  endtask

  task automatic test_typical_calibration();
    coeff_t c;
    c = '{sens: 16'd40127, offset: 16'd36924, sens_tc: 16'd23317, offset_tc: 16'd23282,
          tref: 16'd33464, temp_sens: 16'd28312, double_pressure: 1'b1};
    load_calibration(c);
    send_reading(24'd9085466, 24'd8569150, 1'b0);
    // reading equal to the reference temperature
    send_reading(24'd9085466, 24'd8566784, 1'b0);
    // below 20 C, then below -15 C
    send_reading(24'd9085466, 24'd8200000, 1'b0);
    send_reading(24'd9085466, 24'd7000000, 1'b0);
    send_reading(24'h000000, 24'd8569150, 1'b0);
    send_reading(24'hFFFFFF, 24'd8569150, 1'b0);
    send_reading(24'd9085466, 24'h000000, 1'b0);
    send_reading(24'd9085466, 24'hFFFFFF, 1'b0);
    wait_for_results();
    write_reg(CFG_DOUBLE, 16'h0000);
    send_reading(24'd9085466, 24'd8569150, 1'b0);
  endtask

  task automatic test_register_corners();
    coeff_t c;
    wait_for_results();
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_reading(24'd9085466, 24'd8569150, 1'b0);
    wait_for_results();
    write_reg(CFG_DOUBLE, 16'hFFFF);
    send_reading(24'd9085466, 24'd8569150, 1'b0);
    wait_for_results();
    write_reg(CFG_DOUBLE, 16'hFFFE);
    send_reading(24'd9085466, 24'd8569150, 1'b0);
    c = '{sens: '1, offset: '1, sens_tc: '1, offset_tc: '1, tref: '1, temp_sens: '1,
          double_pressure: 1'b1};
    load_calibration(c);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 1'b0);
    send_reading(24'hFFFFFF, 24'h000000, 1'b0);
    send_reading(24'h000000, 24'h000000, 1'b0);
    send_reading(24'hFFFFFF, 24'hFFFF00, 1'b0);
    c = '0;
    load_calibration(c);
    send_reading(24'hFFFFFF, 24'hFFFFFF, 1'b0);
  endtask

  task automatic test_random_readings();
    coeff_t c;
    int     d1, d2;
    for (int phase = 0; phase < 6; phase++) begin
      c = '{sens: random_coeff(), offset: random_coeff(), sens_tc: random_coeff(),
            offset_tc: random_coeff(), tref: random_coeff(), temp_sens: random_coeff(),
            double_pressure: 1'($urandom())};
      if (phase == 1 || phase == 4) begin
        c = '{sens: '1, offset: '1, sens_tc: '1, offset_tc: '1, tref: '1, temp_sens: '1,
              double_pressure: phase == 1};
      end
      load_calibration(c);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 1))
          d1 = int'($urandom_range(0, 24'hFFFFFF));
        else
          d1 = int'($urandom_range(6000000, 10000000));
        if ($urandom_range(0, 9) < 4) begin
          d2 = int'($urandom_range(0, 24'hFFFFFF));
        end else begin
          d2 = int'(c.tref) * 256 + int'($urandom_range(0, 2097152)) - 1048576;
          if (d2 < 0)
            d2 = 0;
          if (d2 > 24'hFFFFFF)
            d2 = 24'hFFFFFF;
        end
        send_reading(d1[RAW_W-1:0], d2[RAW_W-1:0], phase != 3);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_typical_calibration();
    test_register_corners();
    test_random_readings();
    wait_for_results();
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatch_count == 0 && expected_readings.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
